FILE: rtl/cweb_pkg.sv
// cweb_pkg: shared types and constants of the coincidence window event builder
// no dependencies
`default_nettype none
package cweb_pkg;

  localparam int unsigned Bins1d = 8192;
  localparam int unsigned Bins2d = 512;
  localparam int unsigned MaxOut = 4;
  localparam int unsigned EMin = 20;
  localparam int unsigned ScaleMax = 16;

  localparam int unsigned IdW = 4;
  localparam int unsigned XW = 13;
  localparam int unsigned YW = 9;
  localparam int unsigned EW = 13;
  localparam int unsigned OutCntW = $clog2(MaxOut + 1);
  localparam int unsigned QIdxW = $clog2(MaxOut);

  // register indexes
  localparam logic [2:0] RegFocalWindow = 3'd0;
  localparam logic [2:0] RegSiliconWindow = 3'd1;
  localparam logic [2:0] RegFocalAutoClose = 3'd2;
  localparam logic [2:0] RegSiliconAutoClose = 3'd3;
  localparam logic [2:0] RegTimeScale = 3'd4;

  // channel codes
  localparam logic [15:0] ChFrontHe = 16'd0;
  localparam logic [15:0] ChBackLe = 16'd3;
  localparam logic [15:0] ChE = 16'd4;
  localparam logic [15:0] ChDe = 16'd5;
  localparam logic [15:0] ChSiE = 16'd6;
  localparam logic [15:0] ChSiDe = 16'd7;

  // histogram ids
  localparam logic [IdW-1:0] HSiE = 4'd0;
  localparam logic [IdW-1:0] HSiDe = 4'd1;
  localparam logic [IdW-1:0] HSiDeVsSiE = 4'd2;
  localparam logic [IdW-1:0] HE = 4'd3;
  localparam logic [IdW-1:0] HDe = 4'd4;
  localparam logic [IdW-1:0] HDeVsE = 4'd5;
  localparam logic [IdW-1:0] HPos1 = 4'd6;
  localparam logic [IdW-1:0] HEVsPos1 = 4'd7;
  localparam logic [IdW-1:0] HDeVsPos1 = 4'd8;
  localparam logic [IdW-1:0] HPos2 = 4'd9;
  localparam logic [IdW-1:0] HPos2VsPos1 = 4'd10;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
  } incr_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture hit, evaluate windows
    logic scale;  // divide done, add scaled 2D increments
    logic pop;    // one word taken from output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scale_done;
    logic [OutCntW-1:0] count;
    logic empty;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/coincidence_window_event_builder_core.sv
// coincidence_window_event_builder_core: top level of the event builder
// depends on cweb_pkg, cweb_ctrl, cweb_dp
`default_nettype none
// One hit is taken at a time. A hit first updates both windows and queues its
// direct increments, then passes through a bit-serial signed divider that
// scales both wire positions by time_scale, then adds its scaled 2D
// increments (up to 4 increments per hit in all), and then hands out its
// increment words one at a time as the output takes them. The last word of a hit
// carries last; a hit with no increments gives no word. Configuration writes are
// always accepted and should only be made while idle.
module coincidence_window_event_builder_core import cweb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] channel_i,
  input  wire logic [15:0] charge_i,
  input  wire logic [31:0] timetag_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       hist_id_o,
  output logic [12:0]      bin_x_o,
  output logic [8:0]       bin_y_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  // configuration registers
  logic [23:0] focal_window_q, silicon_window_q;
  logic        focal_auto_close_q, silicon_auto_close_q;
  logic [4:0]  time_scale_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_window_q <= 24'd5000;
      silicon_window_q <= 24'd5000;
      focal_auto_close_q <= 1'b1;
      silicon_auto_close_q <= 1'b1;
      time_scale_q <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFocalWindow: focal_window_q <= cfg_data_i;
        RegSiliconWindow: silicon_window_q <= cfg_data_i;
        RegFocalAutoClose: focal_auto_close_q <= cfg_data_i[0];
        RegSiliconAutoClose: silicon_auto_close_q <= cfg_data_i[0];
        RegTimeScale: time_scale_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  incr_t   head;
  logic    emit;
  logic    sts_busy;
  logic    emit_q;

  cweb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_fire_i(out_valid_o && out_ready_i), .sts_i(sts), .cmd_o(cmd)
  );

  cweb_dp u_dp (
    .clk_i, .rst_ni, .channel_i, .charge_i, .timetag_i,
    .focal_window_i(focal_window_q), .silicon_window_i(silicon_window_q),
    .focal_auto_close_i(focal_auto_close_q), .silicon_auto_close_i(silicon_auto_close_q),
    .time_scale_i(time_scale_q), .cmd_i(cmd), .sts_o(sts), .head_o(head)
  );

  // emit phase: input ready low, divider results added and the queue holds words
  assign emit = !in_ready_o && !sts.empty && !(cmd.scale) && !sts_busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_q <= 1'b0;
    else if (cmd.scale) emit_q <= 1'b1;
    else if (in_ready_o) emit_q <= 1'b0;
  end
  assign sts_busy = !emit_q;

  assign out_valid_o = emit;
  assign hist_id_o = head.id;
  assign bin_x_o = head.x;
  assign bin_y_o = head.y;
  assign last_o = (sts.count == OutCntW'(1));
endmodule
`default_nettype wire

FILE: rtl/cweb_ctrl.sv
// cweb_ctrl: sequencing state machine of the event builder
// depends on cweb_pkg
`default_nettype none
module cweb_ctrl import cweb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    out_fire_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);
  typedef enum logic [1:0] {StIdle, StScale, StEmit} state_e;
  state_e state_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.scale = (state_q == StScale) && sts_i.scale_done;
    cmd_o.pop = (state_q == StEmit) && out_fire_i;
  end
  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StScale;
        StScale: if (sts_i.scale_done) state_q <= StEmit;
        StEmit: if (sts_i.empty || (out_fire_i && sts_i.count == OutCntW'(1))) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cweb_dp.sv
// cweb_dp: window state, position arithmetic, serial divider and result queue
// depends on cweb_pkg
`default_nettype none
module cweb_dp import cweb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] channel_i,
  input  wire logic [15:0] charge_i,
  input  wire logic [31:0] timetag_i,
  input  wire logic [23:0] focal_window_i,
  input  wire logic [23:0] silicon_window_i,
  input  wire logic        focal_auto_close_i,
  input  wire logic        silicon_auto_close_i,
  input  wire logic [4:0]  time_scale_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o,
  output incr_t            head_o
);
  // window state
  logic        f_open_q, s_open_q;
  logic [31:0] f_start_q, s_start_q;
  logic [5:0]  f_flags_q;
  logic [1:0]  s_flags_q;
  logic [EW-1:0] sav_e_q, sav_de_q, si_e_q [2];
  logic [31:0] wire_q [4];
  logic [31:0] pos_q [2];

  // pending work for the scaled stage
  logic        p_front_q, p_dep1_q, p_theta_q;   // EvsPos1/dEvsPos1, dE-late dEvsPos1, theta
  logic        p_dep1_pair_q;
  logic [EW-1:0] p_de_q;

  // queue
  incr_t q_q [MaxOut];
  logic [OutCntW-1:0] cnt_q;

  // divider: two signed divides of 32-bit values by up to 16, 1 bit per cycle on both
  logic [5:0]  div_cnt_q;
  logic        div_busy_q;
  logic [31:0] dq_q [2];
  logic [4:0]  dr_q [2];
  logic        dneg_q [2];
  logic [4:0]  divisor_q;

  always_comb begin
    sts_o.count = cnt_q;
    sts_o.empty = (cnt_q == '0);
    sts_o.scale_done = div_busy_q && (div_cnt_q == 6'd32);
    head_o = q_q[0];
  end

  function automatic logic [31:0] absv(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // 2D bin from quotient: signed(q) + Bins2d/2 in range
  function automatic logic ok2(input logic [31:0] q, input logic neg);
    logic [32:0] s;
    s = (neg ? 33'd0 - {1'b0, q} : {1'b0, q}) + 33'(Bins2d / 2);
    return (s < 33'(Bins2d)) || (neg && q <= 32'(Bins2d / 2));
  endfunction
  function automatic logic [YW-1:0] bin2(input logic [31:0] q, input logic neg);
    logic [31:0] s;
    s = (neg ? 32'd0 - q : q) + 32'(Bins2d / 2);
    return s[YW-1:0];
  endfunction

  // ---- hit evaluation (combinational on load)
  logic [EW-1:0] e;
  logic [15:0]   e16;
  logic          ev;
  logic [31:0]   ts, tf;
  always_comb begin
    e16 = {2'b00, charge_i[15:2]};
    e = e16[EW-1:0];
    ev = (e16 > 16'(EMin)) && (e16 < 16'(Bins1d));
    ts = timetag_i - s_start_q;
    tf = timetag_i - f_start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_open_q <= 1'b0; s_open_q <= 1'b0; f_flags_q <= '0; s_flags_q <= '0;
      f_start_q <= '0; s_start_q <= '0; sav_e_q <= '0; sav_de_q <= '0;
      si_e_q[0] <= '0; si_e_q[1] <= '0;
      for (int i = 0; i < 4; i++) wire_q[i] <= '0;
      pos_q[0] <= '0; pos_q[1] <= '0;
      cnt_q <= '0; div_busy_q <= 1'b0; div_cnt_q <= '0;
      p_front_q <= 1'b0; p_dep1_q <= 1'b0; p_theta_q <= 1'b0; p_dep1_pair_q <= 1'b0;
      p_de_q <= '0; divisor_q <= 5'd1;
      for (int i = 0; i < 2; i++) begin
        dq_q[i] <= '0; dr_q[i] <= '0; dneg_q[i] <= 1'b0;
      end
    end else if (cmd_i.load) begin : ld
      logic [OutCntW-1:0] n;
      logic [5:0] ff;
      logic fo;
      logic [1:0] sf;
      logic [31:0] w [4];
      logic [31:0] p [2];
      logic [31:0] np;
      logic pf, pd, pt, pdp;
      logic [EW-1:0] se0, se1;
      n = '0; pf = 1'b0; pd = 1'b0; pt = 1'b0; pdp = 1'b0;
      for (int i = 0; i < 4; i++) w[i] = wire_q[i];
      p[0] = pos_q[0]; p[1] = pos_q[1];
      se0 = si_e_q[0]; se1 = si_e_q[1];
      // silicon window
      sf = s_flags_q;
      if (!s_open_q) begin
        if (ev && (channel_i == ChSiE || channel_i == ChSiDe)) begin
          s_open_q <= 1'b1; s_start_q <= timetag_i;
          if (channel_i == ChSiE) begin
            s_flags_q <= 2'b01; si_e_q[0] <= e;
            q_q[n[QIdxW-1:0]] <= '{HSiE, e, '0};
          end else begin
            s_flags_q <= 2'b10; si_e_q[1] <= e;
            q_q[n[QIdxW-1:0]] <= '{HSiDe, e, '0};
          end
          n = n + 1'b1;
        end
      end else if (ts > {8'd0, silicon_window_i}) begin
        s_open_q <= 1'b0; s_flags_q <= '0;
      end else if (ev && (channel_i == ChSiE || channel_i == ChSiDe)
                   && !sf[channel_i[0]]) begin
        if (channel_i == ChSiE) begin
          se0 = e; si_e_q[0] <= e; q_q[n[QIdxW-1:0]] <= '{HSiE, e, '0};
        end else begin
          se1 = e; si_e_q[1] <= e; q_q[n[QIdxW-1:0]] <= '{HSiDe, e, '0};
        end
        n = n + 1'b1;
        q_q[n[QIdxW-1:0]] <= '{HSiDeVsSiE, {2'b00, se0[EW-1:2]},
                               se1[EW-1:2] < EW'(Bins2d) ? YW'(se1[EW-1:2]) : '0};
        if ({2'b00, se0[EW-1:2]} < EW'(Bins2d) && se1[EW-1:2] < EW'(Bins2d)) n = n + 1'b1;
        if (silicon_auto_close_i) begin
          s_open_q <= 1'b0; s_flags_q <= '0;
        end else begin
          s_flags_q <= sf | (channel_i == ChSiE ? 2'b01 : 2'b10);
        end
      end
      // focal window
      ff = f_flags_q; fo = f_open_q;
      if (!fo) begin
        if (ev && channel_i == ChE) begin
          f_open_q <= 1'b1; f_start_q <= timetag_i; sav_e_q <= e;
          q_q[n[QIdxW-1:0]] <= '{HE, e, '0}; n = n + 1'b1;
        end
      end else if (tf > {8'd0, focal_window_i}) begin
        f_open_q <= 1'b0; ff = '0;
      end else begin
        if (ev && channel_i == ChDe && !ff[0]) begin
          ff[0] = 1'b1; sav_de_q <= e;
          q_q[n[QIdxW-1:0]] <= '{HDe, e, '0}; n = n + 1'b1;
          if (e[EW-1:2] < EW'(Bins2d) && {2'b00, sav_e_q[EW-1:2]} < EW'(Bins2d)) begin
            q_q[n[QIdxW-1:0]] <= '{HDeVsE, {2'b00, sav_e_q[EW-1:2]}, YW'(e[EW-1:2])};
            n = n + 1'b1;
          end
          if (ff[2:1] == 2'b11) begin
            pd = 1'b1;
          end
        end
        if (channel_i <= ChBackLe && !ff[1 + channel_i[1:0]]) begin
          ff[1 + channel_i[1:0]] = 1'b1;
          w[channel_i[1:0]] = timetag_i;
          wire_q[channel_i[1:0]] <= timetag_i;
          if (ff[1 + (channel_i[1:0] ^ 2'd1)]) begin
            if (!channel_i[1]) begin
              np = w[0] - w[1] + 32'(Bins1d / 2);
              p[0] = np; pos_q[0] <= np;
              if (np < 32'(Bins1d)) begin
                q_q[n[QIdxW-1:0]] <= '{HPos1, np[XW-1:0], '0}; n = n + 1'b1;
              end
              pf = 1'b1; pdp = ff[0];
            end else begin
              np = w[2] - w[3] + 32'(Bins1d / 2);
              p[1] = np; pos_q[1] <= np;
              if (np < 32'(Bins1d)) begin
                q_q[n[QIdxW-1:0]] <= '{HPos2, np[XW-1:0], '0}; n = n + 1'b1;
              end
            end
          end
        end
        if (ff[4:1] == 4'hF && !ff[5]) begin
          ff[5] = 1'b1; pt = 1'b1;
        end
        if (ff == 6'h3F && focal_auto_close_i) begin
          f_open_q <= 1'b0; ff = '0;
        end
      end
      f_flags_q <= ff;
      cnt_q <= n;
      p_front_q <= pf; p_dep1_pair_q <= pdp; p_dep1_q <= pd; p_theta_q <= pt;
      p_de_q <= e;
      // start divider on the positions as they stand after this hit
      divisor_q <= (time_scale_i == 5'd0) ? 5'd1 :
                   (time_scale_i > 5'(ScaleMax)) ? 5'(ScaleMax) : time_scale_i;
      for (int i = 0; i < 2; i++) begin
        np = p[i] - 32'(Bins1d / 2);
        dq_q[i] <= absv(np); dneg_q[i] <= np[31]; dr_q[i] <= '0;
      end
      div_busy_q <= 1'b1; div_cnt_q <= '0;
    end else if (div_busy_q && div_cnt_q != 6'd32) begin
      for (int i = 0; i < 2; i++) begin : stp
        logic [5:0] r;
        r = {dr_q[i], dq_q[i][31]};
        if (r >= {1'b0, divisor_q}) begin
          dr_q[i] <= 5'(r - {1'b0, divisor_q}); dq_q[i] <= {dq_q[i][30:0], 1'b1};
        end else begin
          dr_q[i] <= r[4:0]; dq_q[i] <= {dq_q[i][30:0], 1'b0};
        end
      end
      div_cnt_q <= div_cnt_q + 6'd1;
    end else if (cmd_i.scale) begin : sc
      logic [OutCntW-1:0] n;
      logic ok0, ok1;
      logic [YW-1:0] b0, b1;
      n = cnt_q;
      ok0 = ok2(dq_q[0], dneg_q[0]); ok1 = ok2(dq_q[1], dneg_q[1]);
      b0 = bin2(dq_q[0], dneg_q[0]); b1 = bin2(dq_q[1], dneg_q[1]);
      div_busy_q <= 1'b0;
      if (p_front_q) begin
        if (ok0 && sav_e_q[EW-1:2] < EW'(Bins2d) && n < OutCntW'(MaxOut)) begin
          q_q[n[QIdxW-1:0]] <= '{HEVsPos1, XW'(b0), YW'(sav_e_q[EW-1:2])}; n = n + 1'b1;
        end
        if (p_dep1_pair_q && ok0 && sav_de_q[EW-1:2] < EW'(Bins2d)
            && n < OutCntW'(MaxOut)) begin
          q_q[n[QIdxW-1:0]] <= '{HDeVsPos1, XW'(b0), YW'(sav_de_q[EW-1:2])}; n = n + 1'b1;
        end
      end
      if (p_dep1_q && ok0 && p_de_q[EW-1:2] < EW'(Bins2d) && n < OutCntW'(MaxOut)) begin
        q_q[n[QIdxW-1:0]] <= '{HDeVsPos1, XW'(b0), YW'(p_de_q[EW-1:2])}; n = n + 1'b1;
      end
      if (p_theta_q && ok0 && ok1 && n < OutCntW'(MaxOut)) begin
        q_q[n[QIdxW-1:0]] <= '{HPos2VsPos1, XW'(b0), b1}; n = n + 1'b1;
      end
      cnt_q <= n;
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MaxOut - 1; i++) q_q[i] <= q_q[i + 1];
      cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cweb_checker.sv
// cweb_checker: port-level checks of the event builder, bound to the top level
// depends on cweb_pkg
`default_nettype none
module cweb_checker import cweb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [3:0] hist_id_o,
  input wire logic last_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("word shown while taking hits");
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hist_id_o <= HPos2VsPos1) else $error("bad histogram id");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o) else $error("word after last");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second hit taken");
endmodule

bind coincidence_window_event_builder_core cweb_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .hist_id_o, .last_o
);
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for coincidence_window_event_builder_core
// depends on cweb_pkg and the event builder rtl
`timescale 1ns / 1ps
module testbench;
  import cweb_pkg::*;

  // wire channels that the package leaves unnamed
  localparam logic [15:0] ChFrontLe = 16'd1;
  localparam logic [15:0] ChBackHe = 16'd2;
  localparam int unsigned SettleCycles = 60;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
    logic           last;
  } bin_word_t;

  // one row of the directed hit list; n < 0 means the predictor alone decides
  typedef struct {
    logic [15:0] ch;
    logic [15:0] q;
    logic [31:0] t;
    int          n;
    logic [3:0]  id;
    logic [12:0] x;
    logic [8:0]  y;
  } hit_row_t;

  logic        clk;
  logic        rst_ni;
  logic        in_valid;
  logic [15:0] channel;
  logic [15:0] charge;
  logic [31:0] timetag;
  logic        out_ready;
  logic        cfg_valid;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_ready, out_valid, cfg_ready, last;
  logic [3:0]  hist_id;
  logic [12:0] bin_x;
  logic [8:0]  bin_y;

  coincidence_window_event_builder_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .channel_i  (channel),
    .charge_i   (charge),
    .timetag_i  (timetag),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .hist_id_o  (hist_id),
    .bin_x_o    (bin_x),
    .bin_y_o    (bin_y),
    .last_o     (last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model copy of the registers
  logic [23:0] m_focal_win, m_si_win;
  logic        m_focal_ac, m_si_ac;
  logic [4:0]  m_scale;

  // model copy of both windows
  logic        f_open, s_open;
  logic [31:0] f_start, s_start;
  logic [5:0]  f_flags;   // dE, front HE, front LE, back HE, back LE, both pairs done
  logic [1:0]  s_flags;
  logic [12:0] f_e, f_de;
  logic [12:0] s_e[2];
  logic [31:0] wire_t[4];
  logic [31:0] pos[2];

  bin_word_t hit_words[$];      // words of the hit being predicted
  bin_word_t pending_words[$];  // words the block still owes
  int        errors = 0;
  logic      calm = 1'b0;       // no idling on either side while set

  function automatic void add_word(logic [3:0] id, longint x, longint y);
    bin_word_t w;
    if (hit_words.size() >= MaxOut) return;
    w.id = id;
    w.x = x[12:0];
    w.y = y[8:0];
    w.last = 1'b0;
    hit_words = {hit_words, w};
  endfunction

  function automatic void add_1d(logic [3:0] id, longint x);
    if (x >= 0 && x < Bins1d) add_word(id, x, 0);
  endfunction

  function automatic void add_2d(logic [3:0] id, longint x, longint y);
    if (x >= 0 && x < Bins2d && y >= 0 && y < Bins2d) add_word(id, x, y);
  endfunction

  function automatic longint signed32(logic [31:0] v);
    int s;
    s = $signed(v);
    return longint'(s);
  endfunction

  // centered position divided by the time scale, truncated toward zero
  function automatic longint scale_pos(logic [31:0] p);
    longint d, ts;
    d = signed32(p - 32'(Bins1d / 2));
    ts = m_scale;
    if (ts < 1) ts = 1;
    if (ts > ScaleMax) ts = ScaleMax;
    return d / ts + longint'(Bins2d / 2);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [23:0] d);
    case (idx)
      RegFocalWindow: m_focal_win = d;
      RegSiliconWindow: m_si_win = d;
      RegFocalAutoClose: m_focal_ac = d[0];
      RegSiliconAutoClose: m_si_ac = d[0];
      RegTimeScale: m_scale = d[4:0];
      default: ;
    endcase
  endfunction

  function automatic void clear_model();
    m_focal_win = 24'd5000;
    m_si_win = 24'd5000;
    m_focal_ac = 1'b1;
    m_si_ac = 1'b1;
    m_scale = 5'd1;
    f_open = 0; s_open = 0; f_start = 0; s_start = 0;
    f_flags = 0; s_flags = 0; f_e = 0; f_de = 0;
    s_e[0] = 0; s_e[1] = 0;
    for (int i = 0; i < 4; i++) wire_t[i] = 0;
    pos[0] = 0; pos[1] = 0;
  endfunction

  // works out the histogram words one hit causes and updates both windows
  function automatic void build_event(logic [15:0] ch, logic [15:0] q, logic [31:0] t);
    logic [13:0] e;
    logic        ev;
    int          k;
    longint      sp;
    hit_words.delete();
    e = q[15:2];
    ev = (e > EMin) && (e < Bins1d);
    k = (ch == ChSiE) ? 0 : (ch == ChSiDe) ? 1 : 2;

    // silicon window
    if (!s_open) begin
      if (ev && k < 2) begin
        s_open = 1;
        s_start = t;
        s_flags = 2'(1 << k);
        s_e[k] = e[12:0];
        add_1d(4'(k), e);
      end
    end else if ((t - s_start) > 32'(m_si_win)) begin
      s_open = 0;
      s_flags = 0;
    end else if (ev && k < 2 && !s_flags[k]) begin
      s_flags[k] = 1'b1;
      s_e[k] = e[12:0];
      add_1d(4'(k), e);
      add_2d(HSiDeVsSiE, s_e[0] >> 2, s_e[1] >> 2);
      if (m_si_ac) begin
        s_open = 0;
        s_flags = 0;
      end
    end

    // focal plane window
    if (!f_open) begin
      if (ev && ch == ChE) begin
        f_open = 1;
        f_start = t;
        f_e = e[12:0];
        add_1d(HE, e);
      end
    end else if ((t - f_start) > 32'(m_focal_win)) begin
      f_open = 0;
      f_flags = 0;
    end else begin
      if (ev && ch == ChDe && !f_flags[0]) begin
        f_flags[0] = 1'b1;
        f_de = e[12:0];
        add_1d(HDe, e);
        add_2d(HDeVsE, f_e >> 2, e >> 2);
        if (f_flags[2:1] == 2'b11) add_2d(HDeVsPos1, scale_pos(pos[0]), e >> 2);
      end
      if (ch <= ChBackLe && !f_flags[1 + ch]) begin
        f_flags[1 + ch] = 1'b1;
        wire_t[ch] = t;
        if (f_flags[1 + (ch ^ 1)]) begin
          if (ch < 2) begin
            pos[0] = wire_t[0] - wire_t[1] + 32'(Bins1d / 2);
            add_1d(HPos1, signed32(pos[0]));
            sp = scale_pos(pos[0]);
            add_2d(HEVsPos1, sp, f_e >> 2);
            if (f_flags[0]) add_2d(HDeVsPos1, sp, f_de >> 2);
          end else begin
            pos[1] = wire_t[2] - wire_t[3] + 32'(Bins1d / 2);
            add_1d(HPos2, signed32(pos[1]));
          end
        end
      end
      // both pairs seen: the pos2 vs pos1 word fires once per window
      if (f_flags[4:1] == 4'hF && !f_flags[5]) begin
        f_flags[5] = 1'b1;
        add_2d(HPos2VsPos1, scale_pos(pos[0]), scale_pos(pos[1]));
      end
      if (f_flags == 6'h3F && m_focal_ac) begin
        f_open = 0;
        f_flags = 0;
      end
    end
    if (hit_words.size() > 0) hit_words[hit_words.size() - 1].last = 1'b1;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one hit; valid is left high so the next hit can follow without a gap
  task automatic send_hit(hit_row_t row);
    int gap;
    in_valid <= 1'b1;
    channel <= row.ch;
    charge <= row.q;
    timetag <= row.t;
    do @(posedge clk); while (!in_ready);
    build_event(row.ch, row.q, row.t);
    if (row.n >= 0) begin
      if (hit_words.size() != row.n ||
          (row.n > 0 && (hit_words[0].id != row.id || hit_words[0].x != row.x ||
                         hit_words[0].y != row.y))) begin
        $display("%0t: hit ch %0d: expected %0d words first %0d/%0d/%0d, predicted %0d",
                 $time, row.ch, row.n, row.id, row.x, row.y, hit_words.size());
        errors++;
      end
    end
    pending_words = {pending_words, hit_words};
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every owed word, then let a hit without words finish too
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, d);
  endtask

  task automatic set_regs(logic [23:0] fw, logic [23:0] sw, logic fac, logic sac,
                          logic [23:0] ts);
    write_reg(RegFocalWindow, fw);
    write_reg(RegSiliconWindow, sw);
    write_reg(RegFocalAutoClose, 24'(fac));
    write_reg(RegSiliconAutoClose, 24'(sac));
    write_reg(RegTimeScale, ts);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_charge();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(84, 32767));
    return 16'($urandom());
  endfunction

  // a burst of hits around one timetag: mostly a real event, sometimes noise
  task automatic send_burst(ref int sent, input int pause_at);
    logic [15:0] chans[$];
    logic [15:0] tmp;
    logic [31:0] t0;
    int          spread, j;
    hit_row_t    row;
    t0 = $urandom();
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(3000, 12000)
                                         : $urandom_range(10, 2500);
    if ($urandom_range(0, 6) == 0) begin
      chans = {chans, 16'($urandom())};
      chans = {chans, 16'($urandom_range(0, 9))};
    end else begin
      for (int c = 0; c <= 7; c++)
        if ($urandom_range(0, 9) < 8) chans = {chans, 16'(c)};
      for (int i = chans.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = chans[i]; chans[i] = chans[j]; chans[j] = tmp;
      end
      // the focal window only opens on an E hit
      if ($urandom_range(0, 9) < 7) chans.push_front(ChE);
      if ($urandom_range(0, 3) == 0) chans = {chans, 16'($urandom_range(0, 7))};
    end
    foreach (chans[i]) begin
      row.ch = chans[i];
      row.q = (chans[i] <= ChBackLe) ? 16'($urandom()) : pick_charge();
      row.t = ($urandom_range(0, 15) == 0) ? 32'($urandom())
                                           : t0 + 32'($urandom_range(0, spread));
      row.n = -1;
      row.id = 0; row.x = 0; row.y = 0;
      send_hit(row);
      sent++;
      // sender holds off until the block has caught up
      if (sent == pause_at) drain();
    end
  endtask

  task automatic random_phase(int count, int pause_at);
    int sent;
    sent = 0;
    while (sent < count) send_burst(sent, pause_at);
  endtask

  // directed hits at reset settings; words read off directly where obvious
  hit_row_t directed[] = '{
    '{ChSiE,     16'd400,   32'd0,          1,  HSiE, 13'd100, 9'd0},
    '{ChSiDe,    16'hFFFF,  32'd5,          0,  0, 0, 0},
    '{ChSiDe,    16'd800,   32'd10,         -1, 0, 0, 0},
    '{ChE,       16'd80,    32'd50,         0,  0, 0, 0},
    '{ChE,       16'd84,    32'd100,        1,  HE, 13'd21, 9'd0},
    '{ChDe,      16'd2000,  32'd200,        -1, 0, 0, 0},
    '{ChDe,      16'd3000,  32'd210,        0,  0, 0, 0},
    '{ChFrontHe, 16'd0,     32'd300,        0,  0, 0, 0},
    '{ChFrontLe, 16'hFFFF,  32'd250,        -1, 0, 0, 0},
    '{ChBackHe,  16'd5,     32'd400,        0,  0, 0, 0},
    '{ChBackLe,  16'd7,     32'd1400,       -1, 0, 0, 0},
    '{ChE,       16'd32764, 32'hFFFF_FF00,  1,  HE, 13'd8191, 9'd0},
    '{16'hFFFF,  16'hFFFF,  32'h0000_0010,  0,  0, 0, 0},
    '{ChFrontHe, 16'd0,     32'h0000_0020,  0,  0, 0, 0},
    '{ChFrontLe, 16'd0,     32'h8000_0000,  0,  0, 0, 0},
    '{ChE,       16'd1000,  32'h0000_1000,  1,  HE, 13'd250, 9'd0},
    '{ChFrontHe, 16'd0,     32'h0000_3000,  0,  0, 0, 0},
    '{ChFrontLe, 16'd0,     32'h0000_1000,  -1, 0, 0, 0},
    '{ChDe,      16'd4000,  32'h0000_1100,  -1, 0, 0, 0},
    '{ChSiDe,    16'd32767, 32'h0000_1200,  1,  HSiDe, 13'd8191, 9'd0},
    '{16'd8,     16'd400,   32'h0000_3000,  0,  0, 0, 0},
    '{ChSiE,     16'd88,    32'h0000_3000,  1,  HSiE, 13'd22, 9'd0}
  };

  // receiver: random stalls, compared word by word against the oldest owed one
  int stall_left = 0;
  always @(posedge clk) begin
    bin_word_t w;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word id %0d x %0d y %0d last %0d",
                 $time, hist_id, bin_x, bin_y, last);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (hist_id != w.id || bin_x != w.x || bin_y != w.y || last != w.last) begin
          $display("%0t: expected id %0d x %0d y %0d last %0d, got id %0d x %0d y %0d last %0d",
                   $time, w.id, w.x, w.y, w.last, hist_id, bin_x, bin_y, last);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  initial begin
    clk = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    channel = '0;
    charge = '0;
    timetag = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegFocalWindow;
    cfg_data = '0;
    clear_model();
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_hit(directed[i]);
    drain();

    // extremes: zero-length focal window, widest silicon window, no auto close
    set_regs(24'd0, 24'hFF_FFFF, 1'b0, 1'b0, 24'd0);
    random_phase(95, 40);
    drain();
    calm = 1'b1;
    set_regs(24'hFF_FFFF, 24'd0, 1'b1, 1'b1, 24'd16);
    random_phase(95, -1);
    drain();
    calm = 1'b0;
    set_regs(24'd3000, 24'd3000, 1'b1, 1'b0, 24'h1F);
    random_phase(95, -1);
    drain();
    set_regs(24'($urandom_range(1000, 10000)), 24'($urandom_range(1000, 10000)),
             1'($urandom()), 1'($urandom()), 24'($urandom_range(1, 16)));
    random_phase(95, -1);
    drain();
    set_regs(24'($urandom_range(500, 8000)), 24'($urandom_range(500, 8000)),
             1'b1, 1'b1, 24'($urandom_range(2, 15)));
    random_phase(95, -1);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: coincidence_window_event_builder_core.f
rtl/cweb_pkg.sv
rtl/cweb_ctrl.sv
rtl/cweb_dp.sv
rtl/coincidence_window_event_builder_core.sv
rtl/cweb_checker.sv
tb/sv/testbench.sv
